FILE: design/gha_pkg.sv
// ----------------------------------------------------------------------------
// gha_pkg
// Shared widths, types and GF(2^128) helper functions for the GHASH block.
// ----------------------------------------------------------------------------
package gha_pkg;

  localparam int HALF_W      = 64;
  localparam int BLK_W       = 2 * HALF_W;
  localparam int PROD_W      = 2 * BLK_W - 1;
  localparam int NUM_BYTES   = BLK_W / 8;
  localparam int CNT_W       = 5;
  localparam int IN_FIELD_W  = BLK_W + CNT_W;
  localparam int IN_TDATA_W  = ((IN_FIELD_W + 7) / 8) * 8;
  localparam int OUT_TDATA_W = BLK_W;
  localparam int CFG_IDX_W   = 1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_KEY_HI = 1'b0,
    CFG_KEY_LO = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic             valid;
    logic             restart;
    logic [BLK_W-1:0] blk;
  } item_t;

  // GCM numbers bit 0 of byte 0 as x^0: flip to plain polynomial order
  function automatic logic [BLK_W-1:0] gf_reflect(input logic [BLK_W-1:0] v);
    logic [BLK_W-1:0] r;
    for (int i = 0; i < BLK_W; i++) begin
      r[i] = v[BLK_W-1-i];
    end
    return r;
  endfunction

  function automatic logic [PROD_W-1:0] gf_clmul(input logic [BLK_W-1:0] a,
                                                 input logic [BLK_W-1:0] b);
    logic [PROD_W-1:0] c;
    logic              acc;
    for (int k = 0; k < PROD_W; k++) begin
      acc = 1'b0;
      for (int i = 0; i < BLK_W; i++) begin
        if ((k - i) >= 0 && (k - i) < BLK_W) begin
          acc = acc ^ (a[i] & b[7'(k - i)]);
        end
      end
      c[k] = acc;
    end
    return c;
  endfunction

  // reduce modulo x^128 + x^7 + x^2 + x + 1 in two folds
  function automatic logic [BLK_W-1:0] gf_reduce(input logic [PROD_W-1:0] c);
    logic [2*BLK_W-1:0] w;
    logic [2*BLK_W-1:0] h;
    logic [2*BLK_W-1:0] t;
    logic [BLK_W-1:0]   h2;
    logic [BLK_W-1:0]   t2;
    w  = {1'b0, c};
    h  = {{BLK_W{1'b0}}, w[2*BLK_W-1:BLK_W]};
    t  = h ^ (h << 1) ^ (h << 2) ^ (h << 7);
    h2 = t[2*BLK_W-1:BLK_W];
    t2 = h2 ^ (h2 << 1) ^ (h2 << 2) ^ (h2 << 7);
    return w[BLK_W-1:0] ^ t[BLK_W-1:0] ^ t2;
  endfunction

endpackage

FILE: design/gha_gfmul.sv
// ----------------------------------------------------------------------------
// gha_gfmul
// Combinational GF(2^128) multiplier in GCM bit order.
// ----------------------------------------------------------------------------
module gha_gfmul (
  input  logic [gha_pkg::BLK_W-1:0] x,
  input  logic [gha_pkg::BLK_W-1:0] h,
  output logic [gha_pkg::BLK_W-1:0] z
);

  logic [gha_pkg::PROD_W-1:0] prod;

  assign prod = gha_pkg::gf_clmul(gha_pkg::gf_reflect(x), gha_pkg::gf_reflect(h));
  assign z    = gha_pkg::gf_reflect(gha_pkg::gf_reduce(prod));

endmodule

FILE: design/gha_in_stage.sv
// ----------------------------------------------------------------------------
// gha_in_stage
// Input register: captures a block beat and zeroes bytes past the count.
// ----------------------------------------------------------------------------
module gha_in_stage (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  // [63:0] block_hi, [127:64] block_lo, [132:128] valid_bytes, rest zero
  input  logic [gha_pkg::IN_TDATA_W-1:0] in_tdata,
  // [0] restart
  input  logic                           in_tuser,
  input  logic                           adv,
  output gha_pkg::item_t                 stage
);

  gha_pkg::item_t               stage_r;
  logic [gha_pkg::BLK_W-1:0]    blk_raw;
  logic [gha_pkg::BLK_W-1:0]    blk_masked;
  logic [gha_pkg::CNT_W-1:0]    cnt;
  logic                         accept;

  assign blk_raw = {in_tdata[gha_pkg::HALF_W-1:0],
                    in_tdata[gha_pkg::BLK_W-1:gha_pkg::HALF_W]};
  assign cnt     = in_tdata[gha_pkg::BLK_W +: gha_pkg::CNT_W];

  always_comb begin
    for (int k = 0; k < gha_pkg::NUM_BYTES; k++) begin
      blk_masked[gha_pkg::BLK_W-1-8*k -: 8] =
        (gha_pkg::CNT_W'(k) < cnt) ? blk_raw[gha_pkg::BLK_W-1-8*k -: 8] : 8'h00;
    end
  end

  assign in_tready = !stage_r.valid || adv;
  assign accept    = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_r.valid <= 1'b0;
    end else if (accept) begin
      stage_r.valid   <= 1'b1;
      stage_r.restart <= in_tuser;
      stage_r.blk     <= blk_masked;
    end else if (adv) begin
      stage_r.valid <= 1'b0;
    end
  end

  assign stage = stage_r;

endmodule

FILE: design/ghash_accumulator.sv
// ----------------------------------------------------------------------------
// ghash_accumulator
// GCM GHASH accumulator: Y = (Y xor X) * H over GF(2^128), one block a beat.
// ----------------------------------------------------------------------------
// Usage:
//   Write the hash subkey H through the cfg channel (index CFG_KEY_HI for
//   bytes 0..7, CFG_KEY_LO for bytes 8..15) while the block is idle.
//   Each in beat carries one 128-bit block, a count of leading valid bytes
//   (bytes past it are zeroed; counts above sixteen keep the whole block)
//   and a restart flag in in_tuser that clears Y before the block.
//   Each in beat yields exactly one out beat with the updated Y.
// Pipeline and throughput:
//   A beat is captured in the input register, then the multiply and
//   accumulate run combinationally into the accumulator, which drives
//   out_tdata and out_tvalid. One beat per cycle is sustained while
//   out_tready stays high; the rate is set by the combinational GF(2^128)
//   multiplier on the accumulator feedback loop.
// Reset:
//   Clears H, Y and all valid flags. cfg_ready is always high.
// Stall:
//   While out_tready is low the result and Y hold; one more beat is taken
//   into the input register, then in_tready drops.
// ----------------------------------------------------------------------------
module ghash_accumulator (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // [63:0] block_hi, [127:64] block_lo, [132:128] valid_bytes, rest zero
  input  logic [gha_pkg::IN_TDATA_W-1:0]  in_tdata,
  // [0] restart
  input  logic                            in_tuser,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // [63:0] digest_hi, [127:64] digest_lo
  output logic [gha_pkg::OUT_TDATA_W-1:0] out_tdata,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [gha_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [gha_pkg::HALF_W-1:0]      cfg_data
);

  logic [gha_pkg::HALF_W-1:0] key_hi_r;
  logic [gha_pkg::HALF_W-1:0] key_lo_r;
  logic [gha_pkg::BLK_W-1:0]  accum_r;
  logic                       out_valid_r;
  logic [gha_pkg::BLK_W-1:0]  y_sel;
  logic [gha_pkg::BLK_W-1:0]  prod;
  logic                       adv;
  gha_pkg::item_t             stage;

  gha_in_stage u_in (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .adv       (adv),
    .stage     (stage)
  );

  assign adv   = stage.valid && (!out_valid_r || out_tready);
  assign y_sel = stage.restart ? '0 : accum_r;

  gha_gfmul u_mul (
    .x (y_sel ^ stage.blk),
    .h ({key_hi_r, key_lo_r}),
    .z (prod)
  );

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_hi_r <= '0;
      key_lo_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (gha_pkg::cfg_reg_t'(cfg_index))
        gha_pkg::CFG_KEY_HI: key_hi_r <= cfg_data;
        gha_pkg::CFG_KEY_LO: key_lo_r <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      accum_r     <= '0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      accum_r     <= prod;
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {accum_r[gha_pkg::HALF_W-1:0],
                       accum_r[gha_pkg::BLK_W-1:gha_pkg::HALF_W]};

  a_hold_accum: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_tready) |=> $stable(accum_r))
    else $error("accumulator changed while result stalled");

  a_full_block: assert property (@(posedge clk) disable iff (!rst_n)
    (stage.valid && !adv) |-> !in_tready)
    else $error("input accepted while stage held");

  a_key_write: assert property (@(posedge clk) disable iff (!rst_n)
    (cfg_valid && cfg_ready && cfg_index == gha_pkg::CFG_KEY_HI)
      |=> (key_hi_r == $past(cfg_data)))
    else $error("key high write lost");

  a_restart_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && stage.restart && stage.blk == '0) |=> (accum_r == '0))
    else $error("restart with empty block did not clear accumulator");

endmodule

FILE: verif/tb_ghash_accumulator.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_ghash_accumulator
// Self-checking bench for the GHASH accumulator. A scoreboard class keeps its
// own copy of H and Y and predicts each digest with a bit-serial GF(2^128)
// multiply. Stimulus is a directed set of byte counts, restarts and extreme
// blocks, then random messages under several subkeys, with random idling on
// both sides of the stream.
// ----------------------------------------------------------------------------
module tb_ghash_accumulator;

  localparam int ITEMS_PER_SEG = 108;
  localparam int NUM_SEGS      = 6;
  localparam int STALL_LIMIT   = 2000;

  typedef struct packed {
    bit [63:0] lo;
    bit [63:0] hi;
  } digest_t;

  class ghash_digest_book;
    bit [63:0] key_hi = '0;
    bit [63:0] key_lo = '0;
    bit [63:0] acc_hi = '0;
    bit [63:0] acc_lo = '0;
    digest_t   pending_digests[$];
    int        failures = 0;

    function void load_key(gha_pkg::cfg_reg_t idx, bit [63:0] v);
      case (idx)
        gha_pkg::CFG_KEY_HI: key_hi = v;
        gha_pkg::CFG_KEY_LO: key_lo = v;
        default: ;
      endcase
    endfunction

    function bit [63:0] lead_mask(int n);
      if (n <= 0) return '0;
      if (n >= 8) return '1;
      return ~64'd0 << (64 - 8 * n);
    endfunction

    // Y = (Y ^ X) * H, GCM bit order, reflected shift-and-add
    function void absorb_block(bit [63:0] hi, bit [63:0] lo, bit [4:0] cnt, bit restart);
      int        n;
      bit [63:0] xh, xl, vh, vl, rh, rl;
      bit        lsb;
      digest_t   d;
      n  = (cnt > 16) ? 16 : cnt;
      xh = hi & lead_mask(n);
      xl = lo & lead_mask(n - 8);
      if (!restart) begin
        xh ^= acc_hi;
        xl ^= acc_lo;
      end
      vh = key_hi;
      vl = key_lo;
      rh = '0;
      rl = '0;
      for (int i = 0; i < 128; i++) begin
        if ((i < 64) ? xh[63-i] : xl[127-i]) begin
          rh ^= vh;
          rl ^= vl;
        end
        lsb = vl[0];
        vl  = {vh[0], vl[63:1]};
        vh  = vh >> 1;
        if (lsb) vh ^= 64'hE100_0000_0000_0000;
      end
      acc_hi = rh;
      acc_lo = rl;
      d.hi   = rh;
      d.lo   = rl;
      pending_digests.push_back(d);
    endfunction

    function void report(string what, bit [63:0] exp_v, bit [63:0] got_v);
      failures++;
      if (failures <= 10)
        $display("mismatch %s: expected %016h got %016h", what, exp_v, got_v);
    endfunction

    function void check_digest(digest_t got);
      digest_t want;
      if (pending_digests.size() == 0) begin
        report("unexpected digest_hi", '0, got.hi);
        return;
      end
      want = pending_digests.pop_front();
      if (got.hi !== want.hi) report("digest_hi", want.hi, got.hi);
      if (got.lo !== want.lo) report("digest_lo", want.lo, got.lo);
    endfunction
  endclass

  logic                            clk;
  logic                            rst_n;
  logic                            in_tvalid;
  logic                            in_tready;
  logic [gha_pkg::IN_TDATA_W-1:0]  in_tdata;
  logic                            in_tuser;
  logic                            out_tvalid;
  logic                            out_tready;
  logic [gha_pkg::OUT_TDATA_W-1:0] out_tdata;
  logic                            cfg_valid;
  logic                            cfg_ready;
  logic [gha_pkg::CFG_IDX_W-1:0]   cfg_index;
  logic [gha_pkg::HALF_W-1:0]      cfg_data;

  ghash_digest_book book = new();
  int               in_idle_pct  = 11;
  int               out_idle_pct = 76;
  int               stall_cycles = 0;

  ghash_accumulator i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(negedge clk) begin
    out_tready <= ($urandom_range(99) >= out_idle_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) book.check_digest(digest_t'(out_tdata));
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
      stall_cycles = 0;
    else
      stall_cycles++;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("tb_ghash_accumulator: FAIL");
      $finish;
    end
  end

  task automatic write_key(gha_pkg::cfg_reg_t idx, bit [63:0] v);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = v;
    do @(posedge clk); while (!cfg_ready);
    book.load_key(idx, v);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic write_both_keys(bit [63:0] hi, bit [63:0] lo);
    write_key(gha_pkg::CFG_KEY_HI, hi);
    write_key(gha_pkg::CFG_KEY_LO, lo);
  endtask

  task automatic send_block(bit [63:0] hi, bit [63:0] lo, bit [4:0] cnt, bit restart);
    while ($urandom_range(99) < in_idle_pct) begin
      in_tvalid = 1'b0;
      @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tdata  = gha_pkg::IN_TDATA_W'({cnt, lo, hi});
    in_tuser  = restart;
    do @(posedge clk); while (!in_tready);
    book.absorb_block(hi, lo, cnt, restart);
    @(negedge clk);
  endtask

  task automatic drain();
    in_tvalid = 1'b0;
    while (book.pending_digests.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  function automatic bit [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  initial begin
    bit [4:0] cnt;
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    in_tuser   = 1'b0;
    out_tready = 1'b0;
    cfg_valid  = 1'b0;
    cfg_index  = gha_pkg::CFG_KEY_HI;
    cfg_data   = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // identity subkey first: each digest equals the masked block xor Y (the masked block alone on a restart)
    write_both_keys(64'h8000_0000_0000_0000, 64'h0);
    send_block('1, '1, 5'd16, 1'b0);
    send_block('1, '1, 5'd1, 1'b1);
    send_block('1, '1, 5'd0, 1'b0);
    send_block('1, '1, 5'd0, 1'b1);
    send_block(64'hA5A5_A5A5_A5A5_A5A5, 64'h5A5A_5A5A_5A5A_5A5A, 5'd7, 1'b1);
    send_block('1, '1, 5'd8, 1'b0);
    send_block('1, '1, 5'd9, 1'b0);
    send_block('1, '1, 5'd15, 1'b1);
    send_block('0, '0, 5'd16, 1'b0);
    send_block(rand64(), rand64(), 5'd17, 1'b1);
    send_block(rand64(), rand64(), 5'd24, 1'b0);
    send_block('1, '1, 5'd31, 1'b0);
    drain();
    write_both_keys('1, '1);
    send_block('1, '1, 5'd16, 1'b0);
    send_block('1, '1, 5'd16, 1'b0);
    send_block(rand64(), rand64(), 5'd12, 1'b1);
    send_block(rand64(), rand64(), 5'd3, 1'b0);

    for (int seg = 0; seg < NUM_SEGS; seg++) begin
      drain();
      case (seg / 2)
        0: begin in_idle_pct = 11; out_idle_pct = 76; end
        1: begin in_idle_pct = 76; out_idle_pct = 11; end
        default: begin in_idle_pct = 0; out_idle_pct = 0; end
      endcase
      case (seg)
        0: write_both_keys(rand64(), '1);
        2: write_both_keys('0, '0);
        4: write_both_keys(rand64(), '0);
        default: write_both_keys(rand64(), rand64());
      endcase
      for (int k = 0; k < ITEMS_PER_SEG; k++) begin
        cnt = ($urandom_range(9) < 7) ? 5'd16 : 5'($urandom_range(31));
        send_block(rand64(), rand64(), cnt, $urandom_range(7) == 0);
      end
    end

    drain();
    repeat (4) @(posedge clk);
    book.failures += book.pending_digests.size();
    if (book.failures == 0)
      $display("tb_ghash_accumulator: PASS");
    else
      $display("tb_ghash_accumulator: FAIL");
    $finish;
  end

endmodule
